// File: rtl/core/clqm_pkg.sv
`timescale 1ns / 1ps
package clqm_pkg;

  localparam int LINE_SLOTS_DEF = 16;
  localparam int LINE_CHARS_DEF = 32;

  localparam int KEYWORD_COUNT = 6;
  localparam int KEYWORD_MAX   = 12;
  localparam int KW_BITS       = KEYWORD_MAX * 8;
  localparam int POS_W         = $clog2(KEYWORD_MAX);
  localparam int FUNC_W        = 3;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;

  // Keywords as ASCII bytes, first character in the top byte, zero padded to the right.
  localparam logic [KW_BITS-1:0] KEYWORD_ROM [KEYWORD_COUNT] = '{
    96'h6c65645f616c6c5f6f6e_0000,
    96'h6c65645f616c6c5f6f6666_00,
    96'h6c65645f75705f6f6e_000000,
    96'h6c65645f646f776e5f6f6e_00,
    96'h666c6f7765725f6f6e_000000,
    96'h666c6f7765725f6f6666_0000
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_DONE
  } state_t;

  // Character of a keyword at a position below KEYWORD_MAX.
  function automatic logic [7:0] kw_char(input logic [FUNC_W-1:0] kw,
                                         input logic [POS_W-1:0] pos);
    logic [KW_BITS-1:0] row;
    row = KEYWORD_ROM[kw];
    return row[KW_BITS - 1 - 8 * int'(pos) -: 8];
  endfunction

endpackage

// File: rtl/core/command_line_queue_matcher.sv
`timescale 1ns / 1ps
// A byte request, or a process request on an empty queue, gives its result in the cycle
// after acceptance. A process request on a queued line alternates a memory read (ST_FETCH)
// and a pass of the six-way byte comparator (ST_CMP) for each compared character, at most 12
// characters, then reports from ST_DONE. One request at a time; in_stall is high meanwhile.
// Reset (rst, synchronous, active high) clears the slot pointers, fill count, function
// code and output valid; the line memory is not cleared and needs no clearing pass.
module command_line_queue_matcher #(
  parameter int LINE_SLOTS = clqm_pkg::LINE_SLOTS_DEF,
  parameter int LINE_CHARS = clqm_pkg::LINE_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       line_taken,
  output logic       keyword_matched,
  output logic [2:0] function_code
);

  import clqm_pkg::*;

  localparam int SLOT_W = $clog2(LINE_SLOTS);
  localparam int CHAR_W = $clog2(LINE_CHARS);

  // Control state
  state_t                     state, state_next;
  logic [SLOT_W-1:0]          write_slot;
  logic [SLOT_W-1:0]          read_slot;
  logic [CHAR_W-1:0]          fill_count;
  logic [FUNC_W-1:0]          selected_function;
  logic [POS_W-1:0]           scan_pos;
  logic [KEYWORD_COUNT-1:0]   alive;
  logic                       match_flag;

  // Line memory, one row per slot; rows are always zero terminated before they are read.
  logic [7:0] line_store [LINE_SLOTS][LINE_CHARS];
  logic [7:0] rd_data;

  // Handshake
  logic in_accept;
  logic out_free;
  logic is_eol;
  logic queue_busy;

  // Comparator bank
  logic [KEYWORD_COUNT-1:0] alive_next;
  logic [KEYWORD_COUNT-1:0] hit;
  logic [FUNC_W-1:0]        hit_code;
  logic                     any_hit;

  // Sequencer outputs
  logic load_idle;
  logic load_done;
  logic scan_start;
  logic scan_step;
  logic mem_wr;
  logic [7:0] mem_wdata;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(LINE_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE) || !out_free;
  assign in_accept  = in_valid && !in_stall;
  assign is_eol     = (rx_byte == CH_LF) || (rx_byte == CH_CR);
  assign queue_busy = (write_slot != read_slot);

  // Six byte compares against the current position of every keyword still in the race.
  // A keyword wins when its terminating zero meets a zero in the line.
  always_comb begin
    logic [7:0] want;
    hit_code = '0;
    for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
      want          = kw_char(FUNC_W'(k), scan_pos);
      alive_next[k] = alive[k] && (rd_data == want) && (want != 8'h00);
      hit[k]        = alive[k] && (rd_data == want) && (want == 8'h00);
      if (hit[k]) begin
        hit_code = FUNC_W'(k);
      end
    end
  end

  assign any_hit = |hit;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && cmd == CMD_PROCESS && queue_busy) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_CMP;
      ST_CMP: begin
        if (any_hit || alive_next == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    load_idle  = 1'b0;
    load_done  = 1'b0;
    scan_start = 1'b0;
    scan_step  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (cmd == CMD_PROCESS && queue_busy) begin
            scan_start = 1'b1;
          end else begin
            load_idle = 1'b1;
          end
        end
      end
      ST_FETCH: ;
      ST_CMP:   scan_step = !(any_hit || alive_next == '0);
      ST_DONE:  load_done = out_free;
      default: ;
    endcase
  end

  // Byte path: append a character, or terminate a non-empty line.
  always_comb begin
    mem_wr    = 1'b0;
    mem_wdata = rx_byte;
    if (load_idle && cmd == CMD_BYTE) begin
      if (is_eol) begin
        mem_wr    = (fill_count != '0);
        mem_wdata = 8'h00;
      end else begin
        mem_wr = (fill_count < CHAR_W'(LINE_CHARS - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      line_store[write_slot][fill_count] <= mem_wdata;
    end
    rd_data <= line_store[read_slot][CHAR_W'(scan_pos)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      write_slot        <= '0;
      read_slot         <= '0;
      fill_count        <= '0;
      selected_function <= '0;
      scan_pos          <= '0;
      alive             <= '0;
      match_flag        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;

      if (mem_wr) begin
        if (is_eol) begin
          fill_count <= '0;
          write_slot <= slot_inc(write_slot);
        end else begin
          fill_count <= fill_count + CHAR_W'(1);
        end
      end

      if (scan_start) begin
        scan_pos   <= '0;
        alive      <= '1;
        match_flag <= 1'b0;
      end else if (scan_step) begin
        scan_pos <= scan_pos + POS_W'(1);
        alive    <= alive_next;
      end

      // Latch the winning code as soon as the comparator finds it.
      if (state == ST_CMP && any_hit) begin
        selected_function <= hit_code;
        match_flag        <= 1'b1;
      end

      if (load_done) begin
        read_slot <= slot_inc(read_slot);
      end

      if (load_idle || load_done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load_idle) begin
      line_taken      <= 1'b0;
      keyword_matched <= 1'b0;
      function_code   <= selected_function;
    end else if (load_done) begin
      line_taken      <= 1'b1;
      keyword_matched <= match_flag;
      function_code   <= selected_function;
    end
  end

  a_match_needs_line : assert property (@(posedge clk) disable iff (rst)
    (out_valid && keyword_matched) |-> line_taken)
    else $error("keyword match reported without a consumed line");

  a_scan_bounded : assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (scan_pos < POS_W'(KEYWORD_MAX)))
    else $error("scan ran past the longest keyword");

  a_scan_has_line : assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> queue_busy)
    else $error("scan running on an empty queue");

  a_fill_bounded : assert property (@(posedge clk) disable iff (rst)
    fill_count <= CHAR_W'(LINE_CHARS - 1))
    else $error("fill count beyond the last character position");

  a_slots_bounded : assert property (@(posedge clk) disable iff (rst)
    (write_slot < SLOT_W'(LINE_SLOTS - 1) || write_slot == SLOT_W'(LINE_SLOTS - 1)) &&
    (read_slot < SLOT_W'(LINE_SLOTS - 1) || read_slot == SLOT_W'(LINE_SLOTS - 1)))
    else $error("slot pointer outside the ring");

endmodule

// File: tb/clqm_result_checker.sv
`timescale 1ns / 1ps
module clqm_result_checker #(
  parameter int LINE_SLOTS = clqm_pkg::LINE_SLOTS_DEF,
  parameter int LINE_CHARS = clqm_pkg::LINE_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       line_taken,
  input  logic       keyword_matched,
  input  logic [2:0] function_code,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic                        taken;
    logic                        matched;
    logic [clqm_pkg::FUNC_W-1:0] code;
  } line_result_t;

  // Shadow copy of the line ring and its pointers.
  logic [7:0]                  ring_text [LINE_SLOTS][LINE_CHARS];
  int unsigned                 fill;
  int unsigned                 wr_slot;
  int unsigned                 rd_slot;
  logic [clqm_pkg::FUNC_W-1:0] sel_code;

  line_result_t awaited_results[$];
  int           fail_count;

  // Compare a stored line, up to its first zero, with one keyword.
  function automatic bit line_is_keyword(input int unsigned slot, input int k);
    logic [clqm_pkg::KW_BITS-1:0] row;
    logic [7:0]                   want;
    row = clqm_pkg::KEYWORD_ROM[k];
    for (int p = 0; p < LINE_CHARS; p++) begin
      want = (p < clqm_pkg::KEYWORD_MAX) ? row[clqm_pkg::KW_BITS - 1 - 8 * p -: 8] : 8'h00;
      if (ring_text[slot][p] !== want) return 1'b0;
      if (want == 8'h00) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_line_step(input logic c, input logic [7:0] b);
    line_result_t r;
    r.taken   = 1'b0;
    r.matched = 1'b0;
    if (c == clqm_pkg::CMD_BYTE) begin
      if (b == clqm_pkg::CH_LF || b == clqm_pkg::CH_CR) begin
        if (fill > 0) begin
          ring_text[wr_slot][fill] = 8'h00;
          fill    = 0;
          wr_slot = (wr_slot + 1) % LINE_SLOTS;
        end
      end else if (fill < LINE_CHARS - 1) begin
        ring_text[wr_slot][fill] = b;
        fill++;
      end
    end else if (wr_slot != rd_slot) begin
      r.taken = 1'b1;
      for (int k = 0; k < clqm_pkg::KEYWORD_COUNT; k++) begin
        if (!r.matched && line_is_keyword(rd_slot, k)) begin
          sel_code  = 3'(k);
          r.matched = 1'b1;
        end
      end
      rd_slot = (rd_slot + 1) % LINE_SLOTS;
    end
    r.code = sel_code;
    awaited_results.push_back(r);
  endtask

  task automatic check_line_result();
    line_result_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result taken=%0b matched=%0b code=%0d", $time,
               line_taken, keyword_matched, function_code);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      if (line_taken !== want.taken) begin
        $display("%0t: line_taken expected %0b actual %0b", $time, want.taken, line_taken);
        fail_count++;
      end
      if (keyword_matched !== want.matched) begin
        $display("%0t: keyword_matched expected %0b actual %0b", $time, want.matched,
                 keyword_matched);
        fail_count++;
      end
      if (function_code !== want.code) begin
        $display("%0t: function_code expected %0d actual %0d", $time, want.code,
                 function_code);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill     = 0;
      wr_slot  = 0;
      rd_slot  = 0;
      sel_code = '0;
      awaited_results.delete();
    end else begin
      if (in_valid && !in_stall) predict_line_step(cmd, rx_byte);
      if (out_valid && !out_stall) check_line_result();
    end
    errors  <= fail_count;
    pending <= awaited_results.size();
  end

endmodule

// File: tb/tb_command_line_queue_matcher.sv
`timescale 1ns / 1ps
module tb_command_line_queue_matcher;

  localparam int LINE_SLOTS  = clqm_pkg::LINE_SLOTS_DEF;
  localparam int LINE_CHARS  = clqm_pkg::LINE_CHARS_DEF;
  localparam int ITEM_TARGET = 1500;
  localparam int CYCLE_LIMIT = 1000000;
  // A process request compares at most 12 characters, so drain with margin.
  localparam int DRAIN_WAIT  = 40;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic       cmd       = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       line_taken;
  logic       keyword_matched;
  logic [2:0] function_code;

  int errors;
  int pending;
  int item_count = 0;
  int cycles     = 0;
  bit quiet      = 1'b0;   // when set, neither side idles

  logic [7:0] line_bytes[$];

  command_line_queue_matcher #(
    .LINE_SLOTS (LINE_SLOTS),
    .LINE_CHARS (LINE_CHARS)
  ) uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .line_taken      (line_taken),
    .keyword_matched (keyword_matched),
    .function_code   (function_code)
  );

  clqm_result_checker #(
    .LINE_SLOTS (LINE_SLOTS),
    .LINE_CHARS (LINE_CHARS)
  ) result_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .line_taken      (line_taken),
    .keyword_matched (keyword_matched),
    .function_code   (function_code),
    .errors          (errors),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: stall for a random number of cycles, then take one result.
  initial begin : result_drain
    int hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Hand one request over; idle first, with junk on the payload while valid is low.
  task automatic send_request(input logic c, input logic [7:0] b, input bit counted);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      cmd      <= 1'($urandom);
      rx_byte  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    if (counted) item_count++;
  endtask

  // Any byte but a line end.
  function automatic logic [7:0] text_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (v == clqm_pkg::CH_LF || v == clqm_pkg::CH_CR);
    return v;
  endfunction

  task automatic load_keyword(input int k);
    logic [clqm_pkg::KW_BITS-1:0] row;
    logic [7:0]                   c;
    row = clqm_pkg::KEYWORD_ROM[k];
    for (int p = 0; p < clqm_pkg::KEYWORD_MAX; p++) begin
      c = row[clqm_pkg::KW_BITS - 1 - 8 * p -: 8];
      if (c == 8'h00) break;
      line_bytes.push_back(c);
    end
  endtask

  // Send the built line and close it; bytes past the line width are dropped by the block.
  task automatic send_line(input logic [7:0] term);
    foreach (line_bytes[i])
      send_request(clqm_pkg::CMD_BYTE, line_bytes[i], i < LINE_CHARS - 1);
    send_request(clqm_pkg::CMD_BYTE, term, line_bytes.size() > 0);
  endtask

  function automatic logic [7:0] random_line_end();
    return $urandom_range(0, 1) ? clqm_pkg::CH_LF : clqm_pkg::CH_CR;
  endfunction

  // Mostly exact keywords; the rest near misses, zero-cut lines, noise and over-long lines.
  task automatic build_random_line();
    int kind;
    int pos;
    int n;
    line_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind != 8) load_keyword($urandom_range(0, clqm_pkg::KEYWORD_COUNT - 1));
    case (kind)
      6: begin
        pos = $urandom_range(0, line_bytes.size() - 1);
        case ($urandom_range(0, 2))
          0:       line_bytes[pos] = line_bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
          1:       void'(line_bytes.pop_back());
          default: line_bytes.push_back(text_byte());
        endcase
      end
      7: begin
        // a zero ends the line for the comparison, so the tail must not matter
        line_bytes.push_back(8'h00);
        repeat ($urandom_range(0, 4)) line_bytes.push_back(text_byte());
      end
      8: repeat ($urandom_range(1, 40)) line_bytes.push_back(text_byte());
      9: begin
        n = $urandom_range(LINE_CHARS - 4, LINE_CHARS + 8);
        while (line_bytes.size() < n) line_bytes.push_back(text_byte());
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue, empty line ends, byte extremes with a stored zero, one keyword.
    send_request(clqm_pkg::CMD_PROCESS, 8'hFF, 1'b1);
    send_request(clqm_pkg::CMD_BYTE, clqm_pkg::CH_LF, 1'b1);
    send_request(clqm_pkg::CMD_BYTE, clqm_pkg::CH_CR, 1'b1);
    line_bytes = '{8'hFF, 8'h00};
    send_line(clqm_pkg::CH_LF);
    send_request(clqm_pkg::CMD_PROCESS, 8'h00, 1'b1);
    line_bytes.delete();
    load_keyword(2);
    send_line(clqm_pkg::CH_CR);
    send_request(clqm_pkg::CMD_PROCESS, 8'h00, 1'b1);
    send_request(clqm_pkg::CMD_PROCESS, 8'h00, 1'b1);

    while (item_count < ITEM_TARGET) begin
      if ($urandom_range(0, 29) == 0) quiet = !quiet;
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        // fill the ring up to and past its size so the write slot can wrap over the read slot
        repeat ($urandom_range(LINE_SLOTS - 1, LINE_SLOTS + 3)) begin
          line_bytes.delete();
          load_keyword($urandom_range(0, clqm_pkg::KEYWORD_COUNT - 1));
          send_line(random_line_end());
        end
        repeat ($urandom_range(1, 4))
          send_request(clqm_pkg::CMD_PROCESS, 8'($urandom), 1'b1);
      end else if (pick < 6) begin
        repeat ($urandom_range(1, 6))
          send_request(1'($urandom), 8'($urandom), 1'b1);
      end else begin
        build_random_line();
        send_line(random_line_end());
        if ($urandom_range(0, 7) == 0)
          send_request(clqm_pkg::CMD_BYTE, random_line_end(), 1'b0);
        repeat ($urandom_range(0, 2))
          send_request(clqm_pkg::CMD_PROCESS, 8'($urandom), 1'b1);
      end
    end
    in_valid <= 1'b0;

    // Let the count of awaited results settle, drain it, then hold for stray results.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
